// ===== rtl/telemetry_average_max_aggregator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the telemetry average and peak aggregator
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_AVERAGE_MAX_AGGREGATOR_UNIT_MACROS_SVH
`define TELEMETRY_AVERAGE_MAX_AGGREGATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define TAMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define TAMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/tama_pkg.sv =====
// ----------------------------------------------------------------------------
// tama_pkg
// Types, sizes and codes shared by the telemetry aggregator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tama_pkg;

    // Configuration
    localparam int NUM_SLOTS    = 16;
    localparam int SAMPLE_LIMIT = 64;

    // Field widths
    localparam int SLOT_W   = 4;
    localparam int SAMPLE_W = 16;
    localparam int AVG_W    = 16;
    localparam int USED_W   = 7;

    // Derived storage widths
    localparam int CNT_W = $clog2(SAMPLE_LIMIT + 1);
    localparam int SUM_W = SAMPLE_W + $clog2(SAMPLE_LIMIT);
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int BIT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    // Action codes
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    // Request payload
    typedef struct packed {
        logic                action;
        logic [SLOT_W-1:0]   slot;
        logic [SAMPLE_W-1:0] sample;
    } item_t;

    // Result payload
    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic [AVG_W-1:0]  average;
        logic [SAMPLE_W-1:0] maximum;
        logic [USED_W-1:0] samples_used;
    } result_t;

    // Status of a serial unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tama_serial_update.sv =====
// ----------------------------------------------------------------------------
// tama_serial_update
// Bit-serial sum update and peak compare, one bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module tama_serial_update
    import tama_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SUM_W-1:0]    sum_in,
    input  wire logic [SAMPLE_W-1:0] sample_in,
    input  wire logic [SAMPLE_W-1:0] peak_in,
    output      unit_stat_t          stat,
    output      logic [SUM_W-1:0]    sum_out,
    output      logic                greater
);

    logic [SUM_W-1:0]    acc_reg,    acc_next;
    logic [SUM_W-1:0]    addend_reg, addend_next;
    logic [SAMPLE_W-1:0] peak_reg,   peak_next;
    logic                carry_reg,  carry_next;
    logic                gt_reg,     gt_next;
    logic [BIT_W-1:0]    cnt_reg,    cnt_next;
    logic                busy_reg,   busy_next;
    logic                done_reg,   done_next;

    logic a_bit, b_bit, p_bit, s_bit;

    // Full adder and serial magnitude compare on the low bits
    always_comb
    begin
        a_bit = acc_reg[0];
        b_bit = addend_reg[0];
        p_bit = peak_reg[0];
        s_bit = a_bit ^ b_bit ^ carry_reg;

        acc_next    = acc_reg;
        addend_next = addend_reg;
        peak_next   = peak_reg;
        carry_next  = carry_reg;
        gt_next     = gt_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;

        if (start)
        begin
            acc_next    = sum_in;
            addend_next = SUM_W'(sample_in);
            peak_next   = peak_in;
            carry_next  = 1'b0;
            gt_next     = 1'b0;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next    = {s_bit, acc_reg[SUM_W-1:1]};
            addend_next = addend_reg >> 1;
            peak_next   = peak_reg >> 1;
            carry_next  = (a_bit & b_bit) | (carry_reg & (a_bit ^ b_bit));
            // a higher bit decides; equal bits keep the lower verdict
            gt_next     = (b_bit & ~p_bit) | (~(b_bit ^ p_bit) & gt_reg);
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == BIT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        peak_reg   <= peak_next;
        carry_reg  <= carry_next;
        gt_reg     <= gt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign sum_out   = acc_reg;
    assign greater   = gt_reg;

endmodule

`default_nettype wire

// ===== rtl/tama_serial_div.sv =====
// ----------------------------------------------------------------------------
// tama_serial_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module tama_serial_div
    import tama_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output      unit_stat_t       stat,
    output      logic [SUM_W-1:0] quotient
);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg, dvs_next;
    logic [BIT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [CNT_W:0] trial;
    logic           fits;

    // One shift-and-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[SUM_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits in CNT_W bits
            rem_next = fits ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/telemetry_average_max_aggregator_unit.sv =====
// ----------------------------------------------------------------------------
// telemetry_average_max_aggregator_unit: per-slot running average and peak
// Add: requests stall while the serial update runs, then the slot is written back.
// Report: the divider forms the average, then the result is registered as valid;
// an empty slot skips the divider. A waiting result holds the unit.
// Reset clears all slot sums, counts and peaks at once, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "telemetry_average_max_aggregator_unit_macros.svh"

module telemetry_average_max_aggregator_unit
    import tama_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output      logic    item_stall,
    input  wire item_t   item,
    output      logic    result_valid,
    input  wire logic    result_stall,
    output      result_t result
);

    typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_DIV, ST_HOLD} state_t;

    state_t state_reg;

    // Per-slot statistics
    logic [SUM_W-1:0]    slot_sum_reg  [NUM_SLOTS];
    logic [CNT_W-1:0]    slot_cnt_reg  [NUM_SLOTS];
    logic [SAMPLE_W-1:0] slot_peak_reg [NUM_SLOTS];

    item_t   item_reg;
    result_t res_reg;
    result_t result_reg;
    logic    result_valid_reg;

    logic             accept;
    logic             in_ok;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] cur_idx;
    logic             add_start;
    logic             div_start;
    logic             load_out;

    unit_stat_t       add_stat;
    unit_stat_t       div_stat;
    logic [SUM_W-1:0] add_sum;
    logic             add_gt;
    logic [SUM_W-1:0] div_quo;

    // Request decode
    always_comb
    begin
        accept    = item_valid && !item_stall;
        in_ok     = (32'(item.slot) < NUM_SLOTS);
        in_idx    = IDX_W'(item.slot);
        cur_idx   = IDX_W'(item_reg.slot);
        add_start = accept && (item.action == ACT_ADD) && in_ok;
        div_start = accept && (item.action == ACT_REPORT) && in_ok
                    && (slot_cnt_reg[in_idx] != '0);
        load_out  = (state_reg == ST_HOLD) && (!result_valid_reg || !result_stall);
    end

    assign item_stall = (state_reg != ST_IDLE);

    tama_serial_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (add_start),
        .sum_in    (slot_sum_reg[in_idx]),
        .sample_in (item.sample),
        .peak_in   (slot_peak_reg[in_idx]),
        .stat      (add_stat),
        .sum_out   (add_sum),
        .greater   (add_gt)
    );

    tama_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (slot_sum_reg[in_idx]),
        .divisor  (slot_cnt_reg[in_idx]),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Sequencer, slot store and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
            item_reg         <= '0;
            res_reg          <= '0;
            result_reg       <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_sum_reg[i]  <= '0;
                slot_cnt_reg[i]  <= '0;
                slot_peak_reg[i] <= '0;
            end
        end
        else
        begin
            // a new result load takes priority over the drain
            if (result_valid_reg && !result_stall && !load_out)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= item;
                        if (item.action == ACT_ADD)
                        begin
                            // out-of-range slot: add is dropped
                            if (in_ok)
                            begin
                                state_reg <= ST_ADD;
                            end
                        end
                        else
                        begin
                            res_reg.slot_out <= item.slot;
                            res_reg.average  <= '0;
                            if (in_ok)
                            begin
                                res_reg.maximum      <= slot_peak_reg[in_idx];
                                res_reg.samples_used <= USED_W'(slot_cnt_reg[in_idx]);
                                slot_sum_reg[in_idx]  <= '0;
                                slot_cnt_reg[in_idx]  <= '0;
                                slot_peak_reg[in_idx] <= '0;
                            end
                            else
                            begin
                                res_reg.maximum      <= '0;
                                res_reg.samples_used <= '0;
                            end
                            state_reg <= div_start ? ST_DIV : ST_HOLD;
                        end
                    end
                end

                ST_ADD:
                begin
                    if (add_stat.done)
                    begin
                        if (add_gt)
                        begin
                            slot_peak_reg[cur_idx] <= item_reg.sample;
                        end
                        if (slot_cnt_reg[cur_idx] < CNT_W'(SAMPLE_LIMIT))
                        begin
                            slot_sum_reg[cur_idx] <= add_sum;
                            slot_cnt_reg[cur_idx] <= slot_cnt_reg[cur_idx] + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        res_reg.average <= AVG_W'(div_quo);
                        state_reg       <= ST_HOLD;
                    end
                end

                ST_HOLD:
                begin
                    if (load_out)
                    begin
                        result_reg       <= res_reg;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks on sequencing of the serial units
    `TAMA_ASSERT_IMPL(a_add_done_in_add, clk, rst_n, add_stat.done, state_reg == ST_ADD)
    `TAMA_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_stat.done, state_reg == ST_DIV)
    `TAMA_ASSERT_IMPL(a_add_unit_active, clk, rst_n, state_reg == ST_ADD,
                      add_stat.busy || add_stat.done)
    `TAMA_ASSERT_IMPL(a_div_unit_active, clk, rst_n, state_reg == ST_DIV,
                      div_stat.busy || div_stat.done)
    `TAMA_ASSERT_NEXT(a_load_sets_valid, clk, rst_n, load_out,
                      result_valid && state_reg == ST_IDLE)

endmodule

`default_nettype wire

// ===== tb/sv/telemetry_average_max_aggregator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the telemetry average and peak aggregator
// A driver feeds add and report requests from a queue into the block.
// A monitor tracks per-slot sums, counts and peaks, forms the expected
// report for every accepted report request and compares each returned
// report field by field. Both sides idle in random bursts, and once the
// receiver holds off long enough that the block stops taking requests.
// ----------------------------------------------------------------------------
module telemetry_average_max_aggregator_unit_tb;

    import tama_pkg::*;

    localparam int REQUEST_TARGET = 1350;
    localparam int QUIET_TAIL     = 200;   // last requests run with no idling
    localparam int HOLDOFF_AT     = 300;   // accepted requests before the long hold-off
    localparam int HOLDOFF_CYC    = 250;
    localparam int DRAIN_CYC      = 40;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Stimulus and expected reports
    item_t   request_q[$];
    result_t report_q[$];

    // Slot statistics as the block should hold them
    logic [SUM_W-1:0]    slot_sum  [NUM_SLOTS];
    logic [CNT_W-1:0]    slot_count[NUM_SLOTS];
    logic [SAMPLE_W-1:0] slot_peak [NUM_SLOTS];

    int   fail_count  = 0;
    int   taken_count = 0;
    logic item_taken  = 1'b0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    int   hold_left   = 0;
    logic hold_done   = 1'b0;

    telemetry_average_max_aggregator_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_failure(input string msg);
        $display("ERROR: %s", msg);
        fail_count++;
    endtask

    // Update slot statistics for one request; a report queues its expected result
    task automatic track_request(input item_t req);
        result_t rep;
        int      idx;
        idx = req.slot;
        if (req.action == ACT_ADD)
        begin
            if (idx < NUM_SLOTS)
            begin
                if (req.sample > slot_peak[idx])
                    slot_peak[idx] = req.sample;
                if (slot_count[idx] < SAMPLE_LIMIT)
                begin
                    slot_sum[idx]   = slot_sum[idx] + SUM_W'(req.sample);
                    slot_count[idx] = slot_count[idx] + 1'b1;
                end
            end
        end
        else
        begin
            rep = '0;
            rep.slot_out = req.slot;
            if (idx < NUM_SLOTS)
            begin
                if (slot_count[idx] != 0)
                    rep.average = AVG_W'(slot_sum[idx] / slot_count[idx]);
                rep.maximum      = slot_peak[idx];
                rep.samples_used = USED_W'(slot_count[idx]);
                slot_sum[idx]    = '0;
                slot_count[idx]  = '0;
                slot_peak[idx]   = '0;
            end
            report_q.push_back(rep);
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '1;
            1:       return '0;
            2:       return SAMPLE_W'($urandom_range(0, 15));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic item_t make_request(input logic act, input int slot,
                                           input logic [SAMPLE_W-1:0] smp);
        item_t r;
        r.action = act;
        r.slot   = SLOT_W'(slot);
        r.sample = smp;
        return r;
    endfunction

    // Driver: one request offered at a time, held until accepted
    always @(negedge clk)
    begin
        logic next_valid;
        if (rst_n && !(item_valid && !item_taken))
        begin
            next_valid = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (request_q.size() > 0)
            begin
                if (hold_left == 0 && request_q.size() >= QUIET_TAIL
                    && $urandom_range(0, 7) == 0)
                    gap_left = $urandom_range(1, 13) - 1;
                else
                begin
                    item <= request_q.pop_front();
                    next_valid = 1'b1;
                end
            end
            item_valid <= next_valid;
        end
    end

    // Receiver stall: random bursts plus one long hold-off
    always @(negedge clk)
    begin
        logic next_stall;
        if (rst_n)
        begin
            if (!hold_done && taken_count >= HOLDOFF_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLDOFF_CYC;
            end
            next_stall = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                next_stall = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                next_stall = 1'b1;
            end
            else if (request_q.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                next_stall = 1'b1;
            end
            result_stall <= next_stall;
        end
    end

    // Monitor: check returned reports, then track accepted requests
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (report_q.size() == 0)
                    note_failure($sformatf("report for slot %0d with none expected",
                                           result.slot_out));
                else
                begin
                    want = report_q.pop_front();
                    if (result.slot_out !== want.slot_out)
                        note_failure($sformatf("slot_out got %0d want %0d",
                                               result.slot_out, want.slot_out));
                    if (result.average !== want.average)
                        note_failure($sformatf("slot %0d average got %0d want %0d",
                                               want.slot_out, result.average, want.average));
                    if (result.maximum !== want.maximum)
                        note_failure($sformatf("slot %0d maximum got %0d want %0d",
                                               want.slot_out, result.maximum, want.maximum));
                    if (result.samples_used !== want.samples_used)
                        note_failure($sformatf("slot %0d samples_used got %0d want %0d",
                                               want.slot_out, result.samples_used,
                                               want.samples_used));
                end
            end
            if (item_valid && !item_stall)
            begin
                track_request(item);
                taken_count++;
            end
            item_taken <= item_valid && !item_stall;
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int slot;
        int n;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            slot_sum[k]   = '0;
            slot_count[k] = '0;
            slot_peak[k]  = '0;
        end

        // Directed: field extremes, empty report, floor, peak kept, cleared slot
        request_q.push_back(make_request(ACT_ADD, 15, '1));
        request_q.push_back(make_request(ACT_ADD, 15, '1));
        request_q.push_back(make_request(ACT_REPORT, 15, '0));
        request_q.push_back(make_request(ACT_ADD, 0, '0));
        request_q.push_back(make_request(ACT_REPORT, 0, '1));
        request_q.push_back(make_request(ACT_REPORT, 3, 16'h5A5A));
        request_q.push_back(make_request(ACT_ADD, 5, 16'd1));
        request_q.push_back(make_request(ACT_ADD, 5, 16'd2));
        request_q.push_back(make_request(ACT_REPORT, 5, '0));
        request_q.push_back(make_request(ACT_ADD, 7, 16'd5));
        request_q.push_back(make_request(ACT_ADD, 7, 16'd3));
        request_q.push_back(make_request(ACT_ADD, 7, 16'h8000));
        request_q.push_back(make_request(ACT_ADD, 7, 16'h7FFF));
        request_q.push_back(make_request(ACT_REPORT, 7, '0));
        request_q.push_back(make_request(ACT_REPORT, 7, '0));
        request_q.push_back(make_request(ACT_ADD, 10, 16'hAAAA));
        request_q.push_back(make_request(ACT_ADD, 10, 16'h5555));
        request_q.push_back(make_request(ACT_REPORT, 10, '0));

        // Random: mostly add runs closed by a report, some past the sample limit
        while (request_q.size() < REQUEST_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                slot = $urandom_range(0, NUM_SLOTS - 1);
                case ($urandom_range(0, 9))
                    0:       n = $urandom_range(SAMPLE_LIMIT - 4, SAMPLE_LIMIT + 8);
                    1:       n = 0;
                    default: n = $urandom_range(1, 8);
                endcase
                repeat (n)
                    request_q.push_back(make_request(ACT_ADD, slot, pick_sample()));
                request_q.push_back(make_request(ACT_REPORT, slot, SAMPLE_W'($urandom)));
            end
            else
                request_q.push_back(make_request($urandom_range(0, 1) ? ACT_REPORT : ACT_ADD,
                                                 $urandom_range(0, 15), pick_sample()));
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_q.size() > 0 || item_valid)
            @(posedge clk);
        while (report_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (report_q.size() != 0)
            note_failure($sformatf("%0d reports never returned", report_q.size()));

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
